// ===== hdl/polygon_winding_number_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Polygon winding number unit assertion macros
// Shared assertion macros for the winding number unit; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef POLYGON_WINDING_NUMBER_UNIT_DEFINES_SVH
`define POLYGON_WINDING_NUMBER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define PWN_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("pwn assertion failed");

`define PWN_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("pwn forbidden condition seen");

`else

`define PWN_ASSERT(lbl, clk, rst, prop)

`define PWN_ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

// ===== hdl/pwn_pkg.sv =====
// ----------------------------------------------------------------------------
// Polygon winding number package
// Word types for the request, response and segment job channels.
// ----------------------------------------------------------------------------
package pwn_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
   localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
   localparam int WIND_WIDTH  = 13;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] query_x;
      logic signed [COORD_WIDTH-1:0] query_y;
      logic signed [COORD_WIDTH-1:0] vertex_x;
      logic signed [COORD_WIDTH-1:0] vertex_y;
      logic                          last_vertex;
   } req_type;

   typedef struct packed {
      logic signed [WIND_WIDTH-1:0] winding;
      logic                         inside_res;
   } rsp_type;

   // One polygon segment a -> b, already classified against the query point.
   typedef struct packed {
      logic                         up;
      logic                         down;
      logic signed [DIFF_WIDTH-1:0] dx;
      logic signed [DIFF_WIDTH-1:0] dqy;
      logic signed [DIFF_WIDTH-1:0] dqx;
      logic signed [DIFF_WIDTH-1:0] dy;
   } seg_type;

   typedef struct packed {
      seg_type seg_a;
      seg_type seg_b;
      logic    last;
   } job_type;

endpackage

// ===== hdl/pwn_queue.sv =====
// ----------------------------------------------------------------------------
// Polygon winding number queue
// Small first-in first-out register queue with push/full and pop/empty.
// ----------------------------------------------------------------------------
module pwn_queue #(
   parameter int Width = 1,
   parameter int Depth = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [Width-1:0] push_word,
   output logic             full,
   input  logic             pop,
   output logic [Width-1:0] pop_word,
   output logic             empty
);

   localparam int AddrWidth = $clog2(Depth);

   logic [Width-1:0]     mem_ff [Depth];
   logic [AddrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AddrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [AddrWidth:0]   fill_ff, fill_in;
   logic                 do_push, do_pop;

   assign full     = (fill_ff == (AddrWidth+1)'(Depth));
   assign empty    = (fill_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_word = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

// ===== hdl/pwn_front.sv =====
// ----------------------------------------------------------------------------
// Polygon winding number front end
// Tracks the open polygon and turns each vertex into classified segments.
// ----------------------------------------------------------------------------
module pwn_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  pwn_pkg::req_type req_word,
   output logic             req_full,
   output logic             job_push,
   output pwn_pkg::job_type job_word,
   input  logic             job_full
);

   logic                                   open_ff, open_in;
   logic signed [pwn_pkg::COORD_WIDTH-1:0] start_x_ff, start_x_in;
   logic signed [pwn_pkg::COORD_WIDTH-1:0] start_y_ff, start_y_in;
   logic signed [pwn_pkg::COORD_WIDTH-1:0] prev_x_ff;
   logic signed [pwn_pkg::COORD_WIDTH-1:0] prev_y_ff;
   logic signed [pwn_pkg::COORD_WIDTH-1:0] close_x, close_y;
   logic                                   accept;

   function automatic pwn_pkg::seg_type classify(
      input logic                                   valid,
      input logic signed [pwn_pkg::COORD_WIDTH-1:0] qx,
      input logic signed [pwn_pkg::COORD_WIDTH-1:0] qy,
      input logic signed [pwn_pkg::COORD_WIDTH-1:0] ax,
      input logic signed [pwn_pkg::COORD_WIDTH-1:0] ay,
      input logic signed [pwn_pkg::COORD_WIDTH-1:0] bx,
      input logic signed [pwn_pkg::COORD_WIDTH-1:0] by
   );
      pwn_pkg::seg_type s;
      s.up   = valid && (ay <= qy) && (by > qy);
      s.down = valid && (ay > qy) && (by <= qy);
      s.dx   = {bx[15], bx} - {ax[15], ax};
      s.dqy  = {qy[15], qy} - {ay[15], ay};
      s.dqx  = {qx[15], qx} - {ax[15], ax};
      s.dy   = {by[15], by} - {ay[15], ay};
      return s;
   endfunction

   assign req_full = job_full;
   assign accept   = req_push && !job_full;
   assign job_push = accept;

   assign close_x = open_ff ? start_x_ff : req_word.vertex_x;
   assign close_y = open_ff ? start_y_ff : req_word.vertex_y;

   always_comb begin
      job_word.seg_a = classify(open_ff, req_word.query_x, req_word.query_y,
                                prev_x_ff, prev_y_ff,
                                req_word.vertex_x, req_word.vertex_y);
      job_word.seg_b = classify(req_word.last_vertex, req_word.query_x,
                                req_word.query_y, req_word.vertex_x,
                                req_word.vertex_y, close_x, close_y);
      job_word.last  = req_word.last_vertex;
      open_in        = !req_word.last_vertex;
      start_x_in     = close_x;
      start_y_in     = close_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
      end else if (accept) begin
         open_ff <= open_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         start_x_ff <= start_x_in;
         start_y_ff <= start_y_in;
         prev_x_ff  <= req_word.vertex_x;
         prev_y_ff  <= req_word.vertex_y;
      end
   end

endmodule

// ===== hdl/pwn_back.sv =====
// ----------------------------------------------------------------------------
// Polygon winding number back end
// Evaluates cross product signs, keeps the saturating count, queues results.
// ----------------------------------------------------------------------------
`include "polygon_winding_number_unit_defines.svh"

module pwn_back #(
   parameter int WindBound = 2048
) (
   input  logic             clock,
   input  logic             reset,
   output logic             job_pop,
   input  pwn_pkg::job_type job_word,
   input  logic             job_empty,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output pwn_pkg::rsp_type rsp_word
);

   localparam int CountWidth = $clog2(WindBound + 1) + 1;
   localparam logic signed [CountWidth:0] BoundWide = (CountWidth+1)'(WindBound);
   localparam logic signed [CountWidth-1:0] BoundCount = CountWidth'(WindBound);
   localparam logic signed [1:0] DeltaUp   = 2'sb01;
   localparam logic signed [1:0] DeltaDown = 2'sb11;
   localparam logic signed [1:0] DeltaNone = 2'sb00;

   typedef struct packed {
      logic                                  up;
      logic                                  down;
      logic signed [pwn_pkg::PROD_WIDTH-1:0] prod_l;
      logic signed [pwn_pkg::PROD_WIDTH-1:0] prod_r;
   } prod_type;

   logic                          m_valid_ff, m_valid_in;
   logic                          m_last_ff;
   prod_type                      m_a_ff, m_b_ff, m_a_in, m_b_in;
   logic signed [CountWidth-1:0]  count_ff, count_in;
   logic signed [CountWidth-1:0]  count_mid, count_end;
   logic signed [1:0]             delta_a, delta_b;
   logic                          advance, fire;
   logic                          out_push, out_full;
   pwn_pkg::rsp_type              out_word;

   function automatic prod_type multiply(input pwn_pkg::seg_type s);
      prod_type p;
      p.up     = s.up;
      p.down   = s.down;
      p.prod_l = s.dx * s.dqy;
      p.prod_r = s.dqx * s.dy;
      return p;
   endfunction

   function automatic logic signed [1:0] delta_of(input prod_type p);
      logic signed [pwn_pkg::PROD_WIDTH:0] c;
      logic signed [1:0]                   d;
      c = {p.prod_l[pwn_pkg::PROD_WIDTH-1], p.prod_l}
        - {p.prod_r[pwn_pkg::PROD_WIDTH-1], p.prod_r};
      d = DeltaNone;
      if (p.up && !c[pwn_pkg::PROD_WIDTH] && (|c)) begin
         d = DeltaUp;
      end else if (p.down && c[pwn_pkg::PROD_WIDTH]) begin
         d = DeltaDown;
      end
      return d;
   endfunction

   function automatic logic signed [CountWidth-1:0] bump(
      input logic signed [CountWidth-1:0] c,
      input logic signed [1:0]            d
   );
      logic signed [CountWidth:0] s;
      s = {c[CountWidth-1], c} + {{(CountWidth-1){d[1]}}, d};
      if (s > BoundWide) begin
         s = BoundWide;
      end else if (s < -BoundWide) begin
         s = -BoundWide;
      end
      return s[CountWidth-1:0];
   endfunction

   assign advance = !(m_valid_ff && m_last_ff && out_full);
   assign job_pop = advance && !job_empty;
   assign fire    = m_valid_ff && advance;

   always_comb begin
      m_a_in     = multiply(job_word.seg_a);
      m_b_in     = multiply(job_word.seg_b);
      m_valid_in = advance ? !job_empty : m_valid_ff;
      delta_a    = delta_of(m_a_ff);
      delta_b    = delta_of(m_b_ff);
      count_mid  = bump(count_ff, delta_a);
      count_end  = bump(count_mid, delta_b);
      count_in   = count_ff;
      if (fire) begin
         count_in = m_last_ff ? '0 : count_end;
      end
      out_push            = fire && m_last_ff;
      out_word.winding    = pwn_pkg::WIND_WIDTH'(count_end);
      out_word.inside_res = !count_end[CountWidth-1] && (|count_end);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
         count_ff   <= '0;
      end else begin
         m_valid_ff <= m_valid_in;
         count_ff   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         m_a_ff    <= m_a_in;
         m_b_ff    <= m_b_in;
         m_last_ff <= job_word.last;
      end
   end

   pwn_queue #(
      .Width ($bits(pwn_pkg::rsp_type)),
      .Depth (2)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_word (out_word),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_word  (rsp_word),
      .empty     (rsp_empty)
   );

   `PWN_ASSERT(a_count_in_bounds, clock, reset, (count_ff <= BoundCount) && (count_ff >= -BoundCount))
   `PWN_ASSERT(a_stall_holds_queue, clock, reset, (m_valid_ff && m_last_ff && out_full) |-> !job_pop)
   `PWN_ASSERT(a_result_clears_count, clock, reset, (out_push && !job_pop) |=> (count_ff == '0))
   `PWN_ASSERT_NEVER(a_seg_one_way, clock, reset, m_valid_ff && ((m_a_ff.up && m_a_ff.down) || (m_b_ff.up && m_b_ff.down)))

endmodule

// ===== hdl/polygon_winding_number_unit.sv =====
// ----------------------------------------------------------------------------
// Polygon winding number unit
// Streams polygon vertices with a query point and returns the winding number.
//
//   Channel  Ports                        Word
//   request  req_push, req_full           req_word (vertex, query point, last)
//   response rsp_pop, rsp_empty           rsp_word (winding, inside_res)
//
// One vertex is taken every cycle unless req_full is high; the front end feeds
// a four-word job queue; each result passes the back end into the response queue.
// The back end runs one multiply stage and one count stage per vertex.
// Synchronous reset empties both queues and awaits the first vertex of a polygon.
// A full response queue stalls the back end; a full job queue raises req_full.
// ----------------------------------------------------------------------------
module polygon_winding_number_unit #(
   parameter int MAX_VERTICES = 4096
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  pwn_pkg::req_type req_word,
   output logic             req_full,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output pwn_pkg::rsp_type rsp_word
);

   localparam int WindBound = (MAX_VERTICES / 2 < 2048) ? MAX_VERTICES / 2 : 2048;

   logic             front_push;
   pwn_pkg::job_type front_word;
   logic             job_full;
   logic             job_pop;
   pwn_pkg::job_type job_word;
   logic             job_empty;

   pwn_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_word (req_word),
      .req_full (req_full),
      .job_push (front_push),
      .job_word (front_word),
      .job_full (job_full)
   );

   pwn_queue #(
      .Width ($bits(pwn_pkg::job_type)),
      .Depth (4)
   ) u_job_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_word (front_word),
      .full      (job_full),
      .pop       (job_pop),
      .pop_word  (job_word),
      .empty     (job_empty)
   );

   pwn_back #(
      .WindBound (WindBound)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_pop   (job_pop),
      .job_word  (job_word),
      .job_empty (job_empty),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word)
   );

endmodule

// ===== tb/polygon_winding_checker.sv =====
// ----------------------------------------------------------------------------
// Polygon winding number checker
// Watches the request and response channels of the winding number unit. It
// keeps its own copy of the polygon state, works out the winding number of
// every closed polygon, and compares each popped response word with the
// oldest outstanding winding in order.
// ----------------------------------------------------------------------------
module polygon_winding_checker #(
   parameter int MAX_VERTICES = 4096
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  logic             req_full,
   input  pwn_pkg::req_type req_word,
   input  logic             rsp_pop,
   input  logic             rsp_empty,
   input  pwn_pkg::rsp_type rsp_word,
   output int               mismatch_count,
   output int               pending_count,
   output int               results_checked
);

   localparam int WIND_LIMIT = (MAX_VERTICES / 2) < 2048 ? (MAX_VERTICES / 2) : 2048;

   typedef logic signed [pwn_pkg::COORD_WIDTH-1:0] coord_type;
   typedef logic signed [pwn_pkg::WIND_WIDTH-1:0]  wind_type;

   pwn_pkg::rsp_type expected_windings[$];

   coord_type first_x;
   coord_type first_y;
   coord_type prev_x;
   coord_type prev_y;
   wind_type  tally;
   bit        poly_open;

   initial begin
      mismatch_count  = 0;
      pending_count   = 0;
      results_checked = 0;
   end

   function automatic bit point_left_of(input coord_type qx, input coord_type qy,
                                        input coord_type ax, input coord_type ay,
                                        input coord_type bx, input coord_type by);
      longint cross_val;
      cross_val = (longint'(bx) - longint'(ax)) * (longint'(qy) - longint'(ay))
                - (longint'(qx) - longint'(ax)) * (longint'(by) - longint'(ay));
      return cross_val > 0;
   endfunction

   function automatic int crossing_delta(input coord_type qx, input coord_type qy,
                                         input coord_type ax, input coord_type ay,
                                         input coord_type bx, input coord_type by);
      if (ay <= qy) begin
         if (by > qy && point_left_of(qx, qy, ax, ay, bx, by))
            return 1;
      end else if (by <= qy && point_left_of(qx, qy, bx, by, ax, ay)) begin
         return -1;
      end
      return 0;
   endfunction

   function automatic wind_type bump_tally(input wind_type cur, input int delta);
      int sum;
      sum = int'(cur) + delta;
      if (sum > WIND_LIMIT)
         sum = WIND_LIMIT;
      if (sum < -WIND_LIMIT)
         sum = -WIND_LIMIT;
      return wind_type'(sum);
   endfunction

   task automatic flag_mismatch(input string what, input int want, input int got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("Winding mismatch on %s: expected %0d, got %0d", what, want, got);
   endtask

   task automatic track_vertex(input pwn_pkg::req_type w);
      pwn_pkg::rsp_type exp_word;
      if (!poly_open) begin
         first_x   = w.vertex_x;
         first_y   = w.vertex_y;
         tally     = '0;
         poly_open = 1'b1;
      end else begin
         tally = bump_tally(tally, crossing_delta(w.query_x, w.query_y, prev_x, prev_y,
                                                  w.vertex_x, w.vertex_y));
      end
      prev_x = w.vertex_x;
      prev_y = w.vertex_y;
      if (w.last_vertex) begin
         tally = bump_tally(tally, crossing_delta(w.query_x, w.query_y, w.vertex_x,
                                                  w.vertex_y, first_x, first_y));
         exp_word.winding    = tally;
         exp_word.inside_res = (tally > 0);
         expected_windings.push_back(exp_word);
         tally     = '0;
         poly_open = 1'b0;
      end
   endtask

   task automatic check_response(input pwn_pkg::rsp_type got);
      pwn_pkg::rsp_type want;
      results_checked++;
      if (expected_windings.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("Winding mismatch: response word with winding %0d arrived unasked",
                     got.winding);
         return;
      end
      want = expected_windings.pop_front();
      if (got.winding !== want.winding)
         flag_mismatch("winding", want.winding, got.winding);
      if (got.inside_res !== want.inside_res)
         flag_mismatch("inside_res", want.inside_res, got.inside_res);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_windings.delete();
         first_x   = '0;
         first_y   = '0;
         prev_x    = '0;
         prev_y    = '0;
         tally     = '0;
         poly_open = 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty)
            check_response(rsp_word);
         if (req_push && !req_full)
            track_vertex(req_word);
      end
      pending_count = expected_windings.size();
   end

endmodule

// ===== tb/polygon_winding_number_unit_test.sv =====
// ----------------------------------------------------------------------------
// Polygon winding number unit testbench
// Streams directed polygons, two spirals that wind the count far in both
// directions, a back-pressure burst of tiny polygons and random polygons
// into the unit, with random idle gaps on both channels. A checker beside the
// unit predicts each winding number and compares the response words.
// ----------------------------------------------------------------------------
module polygon_winding_number_unit_test;

   logic             clock = 1'b0;
   logic             reset;
   logic             req_push;
   pwn_pkg::req_type req_word;
   logic             req_full;
   logic             rsp_empty;
   logic             rsp_pop;
   pwn_pkg::rsp_type rsp_word;

   int mismatch_count;
   int pending_count;
   int results_checked;

   int items_sent;
   int polygons_sent;
   int random_start;
   int nverts;
   int spread;
   int qx;
   int qy;
   int vx;
   int vy;
   int shape;
   bit burst;
   bit turn_cw;
   bit rsp_hold_req;
   bit rsp_hold_done;

   polygon_winding_number_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_word  (req_word),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word)
   );

   polygon_winding_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_word        (req_word),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_word        (rsp_word),
      .mismatch_count  (mismatch_count),
      .pending_count   (pending_count),
      .results_checked (results_checked)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #2000000;
      $display("Mismatches found");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      if (r < 98)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int full_coord();
      return int'($urandom_range(0, 65535)) - 32768;
   endfunction

   function automatic int spread_offset(input int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic logic signed [pwn_pkg::COORD_WIDTH-1:0] coord16(input int v);
      if (v > 32767)
         v = 32767;
      if (v < -32768)
         v = -32768;
      return v[pwn_pkg::COORD_WIDTH-1:0];
   endfunction

   function automatic pwn_pkg::req_type make_word(input int px, input int py, input int ax,
                                                  input int ay, input bit last);
      pwn_pkg::req_type w;
      w.query_x     = coord16(px);
      w.query_y     = coord16(py);
      w.vertex_x    = coord16(ax);
      w.vertex_y    = coord16(ay);
      w.last_vertex = last;
      return w;
   endfunction

   task automatic push_word(input pwn_pkg::req_type w, input int gap);
      req_word <= w;
      req_push <= 1'b1;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      items_sent++;
      if (w.last_vertex)
         polygons_sent++;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
   endtask

   // Triangles around the origin, each lap adding one turn in its direction.
   task automatic wind_spiral(input int laps, input bit clockwise, input int back_laps);
      int base_x[3];
      int base_y[3];
      int idx;
      bit dir;
      base_x = '{-100, 100, 0};
      base_y = '{-100, -100, 100};
      for (int i = 0; i < laps + back_laps; i++) begin
         dir = (i < laps) ? clockwise : !clockwise;
         for (int k = 0; k < 3; k++) begin
            idx = dir ? (3 - k) % 3 : k;
            push_word(make_word(0, 0, base_x[idx] + spread_offset(20),
                                base_y[idx] + spread_offset(20),
                                i == laps + back_laps - 1 && k == 2), 0);
         end
      end
   endtask

   initial begin : rsp_drain
      int idle;
      int busy;
      rsp_pop <= 1'b0;
      @(posedge clock);
      forever begin
         if (rsp_hold_req && !rsp_hold_done) begin
            rsp_hold_done = 1'b1;
            rsp_pop <= 1'b0;
            repeat (400) @(posedge clock);
         end else begin
            idle = pick_gap();
            if (idle > 0) begin
               rsp_pop <= 1'b0;
               repeat (idle) @(posedge clock);
            end
            busy = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 6);
            rsp_pop <= 1'b1;
            repeat (busy) @(posedge clock);
         end
      end
   end

   initial begin
      items_sent    = 0;
      polygons_sent = 0;
      rsp_hold_req  = 1'b0;
      rsp_hold_done = 1'b0;
      reset    <= 1'b1;
      req_push <= 1'b0;
      req_word <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Single vertex polygons at the coordinate extremes.
      push_word(make_word(-32768, 32767, 32767, -32768, 1'b1), pick_gap());
      push_word(make_word(32767, -32768, 32767, -32768, 1'b1), pick_gap());
      // Small triangles around the origin, both directions.
      push_word(make_word(0, 0, -100, -100, 1'b0), pick_gap());
      push_word(make_word(0, 0, 100, -100, 1'b0), pick_gap());
      push_word(make_word(0, 0, 0, 100, 1'b1), pick_gap());
      push_word(make_word(0, 0, -100, -100, 1'b0), pick_gap());
      push_word(make_word(0, 0, 0, 100, 1'b0), pick_gap());
      push_word(make_word(0, 0, 100, -100, 1'b1), pick_gap());
      // Full-range triangles, both directions.
      push_word(make_word(0, 0, -32768, -32768, 1'b0), 0);
      push_word(make_word(0, 0, 32767, -32768, 1'b0), 0);
      push_word(make_word(0, 0, 0, 32767, 1'b1), 0);
      push_word(make_word(-1, 1, -32768, -32768, 1'b0), 0);
      push_word(make_word(-1, 1, 0, 32767, 1'b0), 0);
      push_word(make_word(-1, 1, 32767, -32768, 1'b1), 0);
      // Query point on an edge and on a vertex of a square.
      push_word(make_word(5, 0, -5, -5, 1'b0), pick_gap());
      push_word(make_word(5, 0, 5, -5, 1'b0), pick_gap());
      push_word(make_word(5, 0, 5, 5, 1'b0), pick_gap());
      push_word(make_word(5, 5, -5, 5, 1'b1), pick_gap());
      // Query point moving away before the closing edge.
      push_word(make_word(0, 0, -50, -50, 1'b0), pick_gap());
      push_word(make_word(0, 0, 50, -50, 1'b0), pick_gap());
      push_word(make_word(-32768, 32767, 0, 50, 1'b1), pick_gap());
      // Two-vertex polygon.
      push_word(make_word(0, 0, 10, -10, 1'b0), pick_gap());
      push_word(make_word(0, 0, 10, 10, 1'b1), pick_gap());
      wait_drained();

      // Long spirals in both directions, the first turning back a few laps at its end.
      wind_spiral(60, 1'b0, 4);
      wind_spiral(60, 1'b1, 0);
      wait_drained();

      // Responses held off while tiny polygons keep arriving.
      rsp_hold_req = 1'b1;
      for (int i = 0; i < 160; i++) begin
         if ($urandom_range(0, 1) == 0)
            push_word(make_word(full_coord(), full_coord(), full_coord(), full_coord(), 1'b0),
                      0);
         push_word(make_word(full_coord(), full_coord(), full_coord(), full_coord(), 1'b1), 0);
      end

      random_start = items_sent;
      while (items_sent < random_start + 560) begin
         shape = $urandom_range(0, 99);
         if (shape < 10)
            nverts = 1;
         else if (shape < 20)
            nverts = 2;
         else if (shape < 95)
            nverts = $urandom_range(3, 10);
         else
            nverts = $urandom_range(20, 60);
         burst = ($urandom_range(0, 4) == 0);
         case ($urandom_range(0, 3))
            0:       spread = 4;
            3:       spread = 40000;
            default: spread = 300;
         endcase
         if ($urandom_range(0, 3) == 0) begin
            qx = full_coord();
            qy = full_coord();
         end else begin
            qx = spread_offset(1000);
            qy = spread_offset(1000);
         end
         shape   = $urandom_range(0, 9);
         turn_cw = $urandom_range(0, 1);
         for (int v = 0; v < nverts; v++) begin
            if ($urandom_range(0, 9) == 0) begin
               qx = qx + spread_offset(spread);
               qy = qy + spread_offset(spread);
            end
            if (shape < 4) begin
               // Vertices step through the quadrants around the query point.
               vx = $urandom_range(1, spread);
               vy = $urandom_range(1, spread);
               case (turn_cw ? 3 - (v % 4) : v % 4)
                  0: begin vx = qx + vx; vy = qy + vy; end
                  1: begin vx = qx - vx; vy = qy + vy; end
                  2: begin vx = qx - vx; vy = qy - vy; end
                  default: begin vx = qx + vx; vy = qy - vy; end
               endcase
            end else if ($urandom_range(0, 19) == 0) begin
               vx = full_coord();
               vy = full_coord();
            end else begin
               vx = qx + spread_offset(spread);
               vy = qy + spread_offset(spread);
            end
            if ($urandom_range(0, 99) < 15)
               vy = qy;
            if ($urandom_range(0, 99) < 5)
               vx = qx;
            push_word(make_word(qx, qy, vx, vy, v == nverts - 1), burst ? 0 : pick_gap());
         end
      end

      wait_drained();
      repeat (20) @(posedge clock);
      $display("Sent %0d vertex words in %0d polygons; %0d response words checked.",
               items_sent, polygons_sent, results_checked);
      $display("Covered extreme and degenerate polygons, long spirals and a held-off drain.");
      if (mismatch_count == 0 && pending_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
